@@ hw/rtl/msp_pkg.sv @@
package msp_pkg;

  localparam int unsigned PROPERTY_COUNT = 11;
  localparam int unsigned MASK_W         = PROPERTY_COUNT;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EV_RECORD  = 2'd0,
    EV_BUTTON  = 2'd1,
    EV_SUMMARY = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    PH_HDR0  = 2'd0,
    PH_HDR1  = 2'd1,
    PH_LENB  = 2'd2,
    PH_VALUE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_REPLAY = 2'd1,
    ST_SUM    = 2'd2
  } ctl_state_t;

  localparam logic [3:0] CODE_NONE   = 4'd15;
  localparam logic [3:0] CODE_SEQ    = 4'd0;
  localparam logic [3:0] CODE_TEMP   = 4'd1;
  localparam logic [3:0] CODE_HUM    = 4'd2;
  localparam logic [3:0] CODE_TVOC   = 4'd3;
  localparam logic [3:0] CODE_ECO2   = 4'd4;
  localparam logic [3:0] CODE_HEART  = 4'd5;
  localparam logic [3:0] CODE_SPO2   = 4'd6;
  localparam logic [3:0] CODE_RED    = 4'd7;
  localparam logic [3:0] CODE_IR     = 4'd8;
  localparam logic [3:0] CODE_SWITCH = 4'd9;
  localparam logic [3:0] CODE_LIGHT  = 4'd10;

  // Store write request from the byte parser.
  typedef struct packed {
    logic        we;
    logic [3:0]  code;
    logic [31:0] value;
  } store_wr_t;

  function automatic logic [3:0] code_of(input logic [10:0] id);
    logic [3:0] c;
    unique case (id)
      11'h7FF: c = CODE_SEQ;
      11'h04F: c = CODE_TEMP;
      11'h076: c = CODE_HUM;
      11'h102: c = CODE_TVOC;
      11'h008: c = CODE_ECO2;
      11'h100: c = CODE_HEART;
      11'h101: c = CODE_SPO2;
      11'h103: c = CODE_RED;
      11'h104: c = CODE_IR;
      11'h105: c = CODE_SWITCH;
      11'h106: c = CODE_LIGHT;
      default: c = CODE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] need_of(input logic [3:0] code);
    logic [2:0] n;
    if (code == CODE_SEQ || code == CODE_RED || code == CODE_IR) n = 3'd4;
    else if (code == CODE_SWITCH || code == CODE_LIGHT) n = 3'd1;
    else if (code < CODE_SWITCH) n = 3'd2;
    else n = 3'd0;
    return n;
  endfunction

endpackage

@@ hw/rtl/mesh_sensor_status_parser.sv @@
// A payload byte that completes a switch property yields its button event
//   in the output register in the cycle after the request is accepted.
// One request per cycle for begin and payload bytes while the output register is free;
//   after end of message the input is held off while the replay walks every property
//   code, reading the store for each present property, and for the summary and any stalls.
// Reset: synchronous active-low rst_n clears parser and control state; store contents
//   are undefined until written and their read data is only used for properties marked present.
module mesh_sensor_status_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, from bit 0: data_byte[7:0], origin_addr[15:0], rssi[7:0], hops[7:0]
  input  logic [39:0] in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, from bit 0: property_code[3:0], value[31:0], present_mask[10:0],
  //   source_address[15:0], signal_dbm[7:0], hop_count[7:0], rx_ttl[6:0], pad
  output logic [87:0] out_tdata,
  // out_tuser: event_kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  import msp_pkg::*;

  localparam int unsigned IDX_W = $clog2(PROPERTY_COUNT);

  ctl_state_t  state_r, state_nxt;
  logic [6:0]  ttl_r;
  logic [PROPERTY_COUNT-1:0] present_r, present_nxt;
  logic [15:0] src_r;
  logic [7:0]  rssi_r, hops_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [3:0]  ocode_r, ocode_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic        olast_r, olast_nxt;
  logic        ouse_rd_r, ouse_rd_nxt;
  logic [MASK_W-1:0] omask_r, omask_nxt;
  logic        accept, out_free, byte_en, restart;
  cmd_t        cmd;
  store_wr_t   wr;
  logic [31:0] rd_data;
  logic [3:0]  rd_addr;
  logic [6:0]  rx_ttl;

  assign cmd      = cmd_t'(in_tuser);
  assign out_free = !ov_r || out_tready;
  // The parser takes a request only with the output register free, so a button
  // event always has a place to go.
  assign in_tready = (state_r == ST_RUN) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign byte_en   = accept && cmd == CMD_BYTE;
  assign restart   = (accept && cmd == CMD_BEGIN) || (state_r == ST_SUM && out_free);
  assign rd_addr   = 4'(idx_r);

  msp_byte_parser u_parser (
    .clk, .rst_n, .restart, .byte_en, .data_byte(in_tdata[7:0]), .wr
  );

  msp_store u_store (.clk, .wr, .rd_addr, .rd_data);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN:    if (accept && cmd == CMD_END) state_nxt = ST_REPLAY;
      // Replay walks the codes; a read issued for a present code is registered in the store
      // and, once the output register is free, moved into the output register.
      ST_REPLAY: if (out_free && !rd_pend_r && idx_r == IDX_W'(PROPERTY_COUNT - 1) &&
                     !present_r[idx_r]) state_nxt = ST_SUM;
                 else if (out_free && rd_pend_r &&
                     idx_r == IDX_W'(PROPERTY_COUNT - 1)) state_nxt = ST_SUM;
      ST_SUM:    if (out_free) state_nxt = ST_RUN;
      default:   state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    present_nxt = present_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = 1'b0;
    ov_nxt      = ov_r && !out_tready;
    okind_nxt   = okind_r;
    ocode_nxt   = ocode_r;
    oval_nxt    = ouse_rd_r ? rd_data : oval_r;
    ouse_rd_nxt = 1'b0;
    olast_nxt   = olast_r;
    omask_nxt   = omask_r;
    if (wr.we) present_nxt[wr.code] = 1'b1;
    unique case (state_r)
      ST_RUN: begin
        if (accept && cmd == CMD_BEGIN) present_nxt = '0;
        if (accept && cmd == CMD_END) idx_nxt = '0;
        if (wr.we && wr.code == CODE_SWITCH) begin
          ov_nxt    = 1'b1;
          okind_nxt = EV_BUTTON;
          ocode_nxt = CODE_SWITCH;
          oval_nxt  = wr.value;
          olast_nxt = 1'b1;
          omask_nxt = MASK_W'(present_nxt);
        end
      end
      ST_REPLAY: begin
        if (out_free) begin
          if (rd_pend_r) begin
            ov_nxt      = 1'b1;
            okind_nxt   = EV_RECORD;
            ocode_nxt   = 4'(idx_r);
            ouse_rd_nxt = 1'b1;
            olast_nxt   = 1'b0;
            omask_nxt   = MASK_W'(present_r);
            if (idx_r != IDX_W'(PROPERTY_COUNT - 1)) idx_nxt = idx_r + 1'b1;
          end else if (present_r[idx_r]) begin
            rd_pend_nxt = 1'b1;
          end else if (idx_r != IDX_W'(PROPERTY_COUNT - 1)) begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          rd_pend_nxt = rd_pend_r;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          okind_nxt   = EV_SUMMARY;
          ocode_nxt   = CODE_SEQ;
          oval_nxt    = '0;
          olast_nxt   = 1'b1;
          omask_nxt   = MASK_W'(present_r);
          present_nxt = '0;
          idx_nxt     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      ttl_r     <= 7'd5;
      present_r <= '0;
      src_r     <= '0;
      rssi_r    <= '0;
      hops_r    <= '0;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      ov_r      <= 1'b0;
      ouse_rd_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      present_r <= present_nxt;
      idx_r     <= idx_nxt;
      rd_pend_r <= rd_pend_nxt;
      ov_r      <= ov_nxt;
      ouse_rd_r <= ouse_rd_nxt;
      if (cfg_we) ttl_r <= cfg_wdata;
      if (accept && cmd == CMD_BEGIN) begin
        src_r  <= in_tdata[23:8];
        rssi_r <= in_tdata[31:24];
        hops_r <= in_tdata[39:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    ocode_r <= ocode_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    omask_r <= omask_nxt;
  end

  // Message metadata cannot change while a result waits; rx_ttl is combinational and follows cfg_we writes.
  assign rx_ttl = ({1'b0, hops_r} <= {2'b0, ttl_r}) ? ttl_r - hops_r[6:0] : 7'd0;

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {2'b0, rx_ttl, hops_r, rssi_r, src_r, omask_r,
                       ouse_rd_r ? rd_data : oval_r, ocode_r};
endmodule

@@ hw/rtl/msp_store.sv @@
module msp_store (
  input  logic                 clk,
  input  msp_pkg::store_wr_t   wr,
  input  logic [3:0]           rd_addr,
  output logic [31:0]          rd_data
);
  import msp_pkg::*;

  logic [31:0] mem [0:PROPERTY_COUNT-1];

  always_ff @(posedge clk) begin
    if (wr.we && wr.code < 4'(PROPERTY_COUNT)) begin
      mem[wr.code] <= wr.value;
    end
    if (rd_addr < 4'(PROPERTY_COUNT)) begin
      rd_data <= mem[rd_addr];
    end else begin
      rd_data <= '0;
    end
  end
endmodule

@@ hw/rtl/msp_byte_parser.sv @@
module msp_byte_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic               byte_en,
  input  logic [7:0]         data_byte,
  output msp_pkg::store_wr_t wr
);
  import msp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr0_r, hdr0_nxt;
  logic [10:0] id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [8:0]  len_a;
  logic [3:0]  code;
  logic [2:0]  need;
  logic [7:0]  cnt_inc;
  logic [15:0] r16;
  logic [31:0] v;

  assign code    = code_of(id_r);
  assign need    = need_of(code);
  assign cnt_inc = cnt_r + 8'd1;
  assign r16     = shift_nxt[15:0];
  assign len_a   = {5'd0, hdr0_r[4:1]} + 9'd1;

  always_comb begin
    unique case (code)
      CODE_TEMP: v = 32'($signed(r16)) * 32'd10;
      CODE_HUM, CODE_SPO2: v = {16'd0, r16} * 32'd10;
      CODE_TVOC, CODE_ECO2, CODE_HEART: v = {16'd0, r16};
      CODE_SWITCH, CODE_LIGHT: v = {31'd0, shift_nxt[7:0] != 8'd0};
      default: v = shift_nxt;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    hdr0_nxt  = hdr0_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    wr        = '0;
    if (restart) begin
      phase_nxt = PH_HDR0;
      hdr0_nxt  = '0;
      id_nxt    = '0;
      len_nxt   = '0;
      cnt_nxt   = '0;
      shift_nxt = '0;
    end else if (byte_en) begin
      unique case (phase_r)
        PH_HDR0: begin
          hdr0_nxt  = data_byte;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          id_nxt = {data_byte, hdr0_r[7:5]};
          if (!hdr0_r[0]) begin
            len_nxt   = len_a[7:0];
            cnt_nxt   = '0;
            shift_nxt = '0;
            phase_nxt = PH_VALUE;
          end else begin
            phase_nxt = PH_LENB;
          end
        end
        PH_LENB: begin
          len_nxt   = data_byte;
          cnt_nxt   = '0;
          shift_nxt = '0;
          phase_nxt = (data_byte == 8'd0) ? PH_HDR0 : PH_VALUE;
        end
        default: begin
          if (cnt_r < 8'd4) begin
            shift_nxt = shift_r | ({24'd0, data_byte} << {cnt_r[1:0], 3'b000});
          end
          cnt_nxt = cnt_inc;
          if (code != CODE_NONE && need != 3'd0 && len_r >= {5'd0, need} &&
              cnt_inc == {5'd0, need}) begin
            wr.we    = 1'b1;
            wr.code  = code;
            wr.value = v;
          end
          if (cnt_inc >= len_r) phase_nxt = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      hdr0_r  <= '0;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      shift_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      hdr0_r  <= hdr0_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
    end
  end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import msp_pkg::*;

  // A byte-stream request to the parser: command plus its payload fields.
  typedef struct {
    cmd_t        cmd;
    logic [7:0]  data_byte;
    logic [15:0] src;
    logic [7:0]  rssi;
    logic [7:0]  hops;
  } request_t;

  // One emitted event, as carried on the result channel.
  typedef struct packed {
    event_t      kind;
    logic [3:0]  code;
    logic [31:0] value;
    logic [10:0] mask;
    logic [15:0] src;
    logic [7:0]  rssi;
    logic [7:0]  hops;
    logic [6:0]  ttl;
    logic        last;
  } event_rec_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        in_taken;

  mesh_sensor_status_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // The clock runs with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  request_t   pending_reqs[$];
  event_rec_t expected_events[$];
  int         mismatches;
  int         send_idle_pct;
  int         recv_stall_pct;

  // Shadow copy of the parser's state, advanced once per accepted request.
  logic [6:0]  pub_ttl;
  phase_t      phase;
  logic [7:0]  hdr0;
  logic [10:0] prop_id;
  logic [7:0]  val_len;
  logic [7:0]  val_cnt;
  logic [31:0] val_acc;
  logic [31:0] stored_val[11];
  logic [10:0] present;
  logic [15:0] msg_src;
  logic [7:0]  msg_rssi;
  logic [7:0]  msg_hops;

  function automatic logic [3:0] prop_code(input logic [10:0] id);
    case (id)
      11'h7FF: return CODE_SEQ;
      11'h04F: return CODE_TEMP;
      11'h076: return CODE_HUM;
      11'h102: return CODE_TVOC;
      11'h008: return CODE_ECO2;
      11'h100: return CODE_HEART;
      11'h101: return CODE_SPO2;
      11'h103: return CODE_RED;
      11'h104: return CODE_IR;
      11'h105: return CODE_SWITCH;
      11'h106: return CODE_LIGHT;
      default: return CODE_NONE;
    endcase
  endfunction

  // Number of value bytes a property needs before it can be stored.
  function automatic int bytes_needed(input logic [3:0] code);
    if (code == CODE_SEQ || code == CODE_RED || code == CODE_IR) return 4;
    if (code == CODE_SWITCH || code == CODE_LIGHT) return 1;
    if (code < CODE_SWITCH) return 2;
    return 0;
  endfunction

  function automatic logic [31:0] scale_value(input logic [3:0] code, input logic [31:0] raw);
    case (code)
      CODE_TEMP: return 32'($signed(raw[15:0])) * 32'd10;
      CODE_HUM, CODE_SPO2: return {16'd0, raw[15:0]} * 32'd10;
      CODE_TVOC, CODE_ECO2, CODE_HEART: return {16'd0, raw[15:0]};
      CODE_SWITCH, CODE_LIGHT: return (raw[7:0] != 8'd0) ? 32'd1 : 32'd0;
      default: return raw;
    endcase
  endfunction

  function automatic event_rec_t make_event(input event_t kind, input logic [3:0] code,
                                           input logic [31:0] value, input logic last);
    event_rec_t e;
    e.kind  = kind;
    e.code  = code;
    e.value = value;
    e.mask  = present;
    e.src   = msg_src;
    e.rssi  = msg_rssi;
    e.hops  = msg_hops;
    e.ttl   = ({1'b0, msg_hops} <= {2'b0, pub_ttl}) ? 7'(pub_ttl - msg_hops) : 7'd0;
    e.last  = last;
    return e;
  endfunction

  task automatic restart_parse();
    phase   = PH_HDR0;
    hdr0    = '0;
    prop_id = '0;
    val_len = '0;
    val_cnt = '0;
    val_acc = '0;
  endtask

  task automatic open_value();
    val_cnt = '0;
    val_acc = '0;
    phase   = (val_len == 8'd0) ? PH_HDR0 : PH_VALUE;
  endtask

  // Advance the shadow parser by one request and queue whatever it emits.
  task automatic predict_events(input request_t r);
    logic [15:0] w;
    logic [3:0]  code;
    int          need;
    case (r.cmd)
      CMD_BEGIN: begin
        msg_src  = r.src;
        msg_rssi = r.rssi;
        msg_hops = r.hops;
        present  = '0;
        restart_parse();
      end
      CMD_BYTE: begin
        case (phase)
          PH_HDR0: begin
            hdr0  = r.data_byte;
            phase = PH_HDR1;
          end
          PH_HDR1: begin
            if (!hdr0[0]) begin
              // Format A: ID and length minus one share one 16-bit word.
              w       = {r.data_byte, hdr0};
              prop_id = w[15:5];
              val_len = {4'd0, w[4:1]} + 8'd1;
              open_value();
            end else begin
              // Format B: the length follows in its own byte.
              prop_id = {r.data_byte, hdr0[7:5]};
              phase   = PH_LENB;
            end
          end
          PH_LENB: begin
            val_len = r.data_byte;
            open_value();
          end
          default: begin
            code = prop_code(prop_id);
            need = bytes_needed(code);
            if (val_cnt < 8'd4) val_acc |= 32'(r.data_byte) << (8 * val_cnt);
            val_cnt = val_cnt + 8'd1;
            if (code != CODE_NONE && need != 0 && val_len >= need && val_cnt == need) begin
              stored_val[code] = scale_value(code, val_acc);
              present[code] = 1'b1;
              if (code == CODE_SWITCH)
                expected_events.push_back(make_event(EV_BUTTON, CODE_SWITCH,
                                                     stored_val[code], 1'b1));
            end
            if (val_cnt >= val_len) phase = PH_HDR0;
          end
        endcase
      end
      CMD_END: begin
        for (int i = 0; i < 11; i++)
          if (present[i])
            expected_events.push_back(make_event(EV_RECORD, 4'(i), stored_val[i], 1'b0));
        expected_events.push_back(make_event(EV_SUMMARY, CODE_SEQ, 32'd0, 1'b1));
        present = '0;
        restart_parse();
      end
      default: ;
    endcase
  endtask

  // Remembers whether the last rising edge took the presented request.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // Driver: presents the oldest pending request, with random idle cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // Hold the request until it is taken.
    end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_tvalid <= 1'b1;
      in_tuser  <= pending_reqs[0].cmd;
      in_tdata  <= {pending_reqs[0].hops, pending_reqs[0].rssi, pending_reqs[0].src,
                    pending_reqs[0].data_byte};
      void'(pending_reqs.pop_front());
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts on each accepted request and checks each accepted event.
  always @(posedge clk) begin
    request_t   r;
    event_rec_t got;
    event_rec_t exp_ev;
    if (rst_n && in_tvalid && in_tready) begin
      r.cmd       = cmd_t'(in_tuser);
      r.data_byte = in_tdata[7:0];
      r.src       = in_tdata[23:8];
      r.rssi      = in_tdata[31:24];
      r.hops      = in_tdata[39:32];
      predict_events(r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.kind  = event_t'(out_tuser);
      got.code  = out_tdata[3:0];
      got.value = out_tdata[35:4];
      got.mask  = out_tdata[46:36];
      got.src   = out_tdata[62:47];
      got.rssi  = out_tdata[70:63];
      got.hops  = out_tdata[78:71];
      got.ttl   = out_tdata[85:79];
      got.last  = out_tlast;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: kind %0d code %0d value %h", got.kind, got.code,
                   got.value);
      end else begin
        exp_ev = expected_events.pop_front();
        if (got != exp_ev) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: exp %p got %p", exp_ev, got);
        end
      end
    end
  end

  // Builds one property header, choosing format A or B at random when the length fits format A, else format B.
  task automatic push_header(input logic [10:0] id, input int len);
    request_t r;
    r = '{CMD_BYTE, 8'd0, 16'd0, 8'd0, 8'd0};
    if (len >= 1 && len <= 16 && $urandom_range(1)) begin
      r.data_byte = {id[2:0], 4'(len - 1), 1'b0};
      pending_reqs.push_back(r);
      r.data_byte = id[10:3];
      pending_reqs.push_back(r);
    end else begin
      r.data_byte = {id[2:0], 4'($urandom_range(15)), 1'b1};
      pending_reqs.push_back(r);
      r.data_byte = id[10:3];
      pending_reqs.push_back(r);
      r.data_byte = 8'(len);
      pending_reqs.push_back(r);
    end
  endtask

  task automatic push_req(input cmd_t c, input logic [7:0] b);
    request_t r;
    r.cmd       = c;
    r.data_byte = b;
    r.src       = 16'($urandom);
    r.rssi      = 8'($urandom);
    r.hops      = 8'($urandom_range(9)) ? 8'($urandom_range(12)) : 8'($urandom);
    pending_reqs.push_back(r);
  endtask

  // A well-formed message with random properties, sometimes broken at the tail.
  task automatic push_message(input int nprops);
    logic [10:0] ids[12];
    logic [10:0] id;
    int          len;
    ids = '{11'h7FF, 11'h04F, 11'h076, 11'h102, 11'h008, 11'h100, 11'h101,
            11'h103, 11'h104, 11'h105, 11'h106, 11'h000};
    push_req(CMD_BEGIN, 8'($urandom));
    for (int p = 0; p < nprops; p++) begin
      id  = ($urandom_range(7) == 0) ? 11'($urandom) : ids[$urandom_range(10)];
      len = bytes_needed(prop_code(id));
      case ($urandom_range(9))
        0: len = $urandom_range(3);
        1: len = len + $urandom_range(4);
        default: ;
      endcase
      push_header(id, len);
      for (int k = 0; k < len; k++) push_req(CMD_BYTE, 8'($urandom));
    end
    if ($urandom_range(5) == 0) push_req(CMD_BYTE, 8'($urandom));
    if ($urandom_range(15) == 0) push_req(CMD_NONE, 8'($urandom));
    push_req(CMD_END, 8'($urandom));
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_events.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [6:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pub_ttl    = v;
  endtask

  initial begin
    request_t r;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = CMD_NONE;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pub_ttl        = 7'd5;
    present        = '0;
    msg_src        = '0;
    msg_rssi       = '0;
    msg_hops       = '0;
    restart_parse();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: bytes before any begin use the reset metadata and TTL.
    push_header(11'h105, 1);
    push_req(CMD_BYTE, 8'h00);
    push_req(CMD_END, 8'h00);
    r = '{CMD_BEGIN, 8'hFF, 16'hFFFF, 8'h80, 8'hFF};
    pending_reqs.push_back(r);
    // Negative temperature, full-scale humidity, switch pressed.
    pending_reqs.push_back('{CMD_BYTE, 8'hE2, 16'h0, 8'h0, 8'h0});
    pending_reqs.push_back('{CMD_BYTE, 8'h09, 16'h0, 8'h0, 8'h0});
    pending_reqs.push_back('{CMD_BYTE, 8'h00, 16'h0, 8'h0, 8'h0});
    pending_reqs.push_back('{CMD_BYTE, 8'h80, 16'h0, 8'h0, 8'h0});
    push_header(11'h076, 2);
    push_req(CMD_BYTE, 8'hFF);
    push_req(CMD_BYTE, 8'hFF);
    // Zero-length format B property, then a short-length one that is skipped.
    push_header(11'h7FF, 0);
    push_header(11'h7FF, 2);
    push_req(CMD_BYTE, 8'h12);
    push_req(CMD_BYTE, 8'h34);
    push_header(11'h105, 1);
    push_req(CMD_BYTE, 8'h7F);
    push_req(CMD_NONE, 8'h00);
    push_req(CMD_END, 8'h00);
    drain();

    write_ttl(7'd127);
    push_message(3);
    drain();
    write_ttl(7'd0);
    push_message(2);
    drain();

    // Random part in four pressure phases, each with its own TTL setting.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      write_ttl(7'($urandom));
      for (int m = 0; m < 5; m++) begin
        if ($urandom_range(6) == 0) push_req(cmd_t'($urandom_range(3)), 8'($urandom));
        else push_message($urandom_range(1, 6));
      end
      drain();
    end
    write_ttl(7'd127);
    push_message(11);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
